[rtl/residual_alert_confirm_revert_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the residual alert confirm/revert block
// Short forms for clocked implication checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RESIDUAL_ALERT_CONFIRM_REVERT_ASSERT_SVH
`define RESIDUAL_ALERT_CONFIRM_REVERT_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define RACR_ASSERT_SAME(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define RACR_ASSERT_NEXT(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[rtl/racr_pkg.sv]
// ----------------------------------------------------------------------------
// Residual alert confirm/revert package
// Shared constants, register indexes, item types and a helper function.
// ----------------------------------------------------------------------------
package racr_pkg;

    localparam int MAX_IMAGES = 256;

    localparam int THR_W      = 24;
    localparam int GAIN_W     = 16;
    localparam int RUN_W      = 8;
    localparam int IDX_W      = 8;
    localparam int OBS_W      = 16;
    localparam int PRED_W     = 24;
    localparam int VAR_W      = 16;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD  = 2'd0,
        REG_GAIN       = 2'd1,
        REG_RUN_LENGTH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                     first_of_pixel;
        logic                     last_of_pixel;
        logic                     obs_valid;
        logic [IDX_W-1:0]         image_index;
        logic signed [OBS_W-1:0]  observed;
        logic signed [PRED_W-1:0] predicted;
        logic signed [VAR_W-1:0]  pixel_variability;
    } sample_t;

    typedef struct packed {
        logic             detected;
        logic [IDX_W-1:0] candidate_index;
        logic [CNT_W-1:0] confirm_events;
        logic [CNT_W-1:0] revert_events;
    } result_t;

    typedef struct packed {
        logic             confirmed_flag;
        logic [RUN_W-1:0] alert_run;
        logic [RUN_W-1:0] calm_run;
        logic [IDX_W-1:0] candidate;
        logic [CNT_W-1:0] confirm_count;
        logic [CNT_W-1:0] revert_count;
    } pixel_state_t;

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
    endfunction

endpackage

[rtl/racr_if.sv]
// ----------------------------------------------------------------------------
// Residual alert confirm/revert channel interfaces
// Valid/ready channels for observation items and for pixel results.
// ----------------------------------------------------------------------------
interface racr_sample_if import racr_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     first_of_pixel;
    logic                     last_of_pixel;
    logic                     obs_valid;
    logic [IDX_W-1:0]         image_index;
    logic signed [OBS_W-1:0]  observed;
    logic signed [PRED_W-1:0] predicted;
    logic signed [VAR_W-1:0]  pixel_variability;

    modport source (
        output valid, first_of_pixel, last_of_pixel, obs_valid, image_index,
               observed, predicted, pixel_variability,
        input  ready
    );

    modport sink (
        input  valid, first_of_pixel, last_of_pixel, obs_valid, image_index,
               observed, predicted, pixel_variability,
        output ready
    );
endinterface

interface racr_result_if import racr_pkg::*;;
    logic             valid;
    logic             ready;
    logic             detected;
    logic [IDX_W-1:0] candidate_index;
    logic [CNT_W-1:0] confirm_events;
    logic [CNT_W-1:0] revert_events;

    modport source (
        output valid, detected, candidate_index, confirm_events, revert_events,
        input  ready
    );

    modport sink (
        input  valid, detected, candidate_index, confirm_events, revert_events,
        output ready
    );
endinterface

[rtl/residual_alert_confirm_revert.sv]
// ----------------------------------------------------------------------------
// Residual alert confirm/revert detector
// Per-pixel disturbance detector with alert confirmation and calm reversion.
// ----------------------------------------------------------------------------
// The block takes one observation per clock cycle, and so keeps up with an
// unbroken stream, while no last observation waits for an untaken result. An
// observation is first captured in an input register; the single per-pixel
// state update (one 16x16 multiply for the variability limit plus the residual
// compares) then runs from that register and, for a last observation, loads
// the result register, which presents the pixel result. Only an observation
// marked as last of its pixel produces a result; while an earlier result still
// waits to be taken, observations that produce no result keep flowing, and a
// last observation waits in the input register until the result is taken.
module residual_alert_confirm_revert import racr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    racr_sample_if.sink           sample,
    racr_result_if.source         result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [16:0] IdxLimit = 17'(MAX_IMAGES - 1);

    logic signed [THR_W-1:0]  thr_reg;
    logic signed [GAIN_W-1:0] gain_reg;
    logic [RUN_W-1:0]         run_len_reg;

    sample_t      sample_reg;
    logic         sample_valid_reg;
    pixel_state_t state_reg;
    pixel_state_t state_next;
    pixel_state_t base;
    result_t      result_reg;
    logic         result_valid_reg;
    logic         advance;

    logic signed [23:0] obs_q8;
    logic signed [24:0] res;
    logic signed [31:0] lim;
    logic signed [32:0] res_x;
    logic signed [32:0] lim_x;
    logic signed [32:0] thr_x;
    logic signed [25:0] res2;
    logic signed [25:0] thr2_x;
    logic               thr_pos;
    logic               thr_neg;
    logic               alert;
    logic               calm;
    logic [IDX_W-1:0]   cand_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= '0;
            gain_reg    <= 16'sd256;
            run_len_reg <= 8'd3;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD:  thr_reg     <= cfg_data[THR_W-1:0];
                REG_GAIN:       gain_reg    <= cfg_data[GAIN_W-1:0];
                REG_RUN_LENGTH: run_len_reg <= cfg_data[RUN_W-1:0];
                default:        ;
            endcase
        end
    end

    assign advance = sample_valid_reg &&
                     (!sample_reg.last_of_pixel || !result_valid_reg || result.ready);
    assign sample.ready = !sample_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            sample_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            sample_reg.first_of_pixel    <= sample.first_of_pixel;
            sample_reg.last_of_pixel     <= sample.last_of_pixel;
            sample_reg.obs_valid         <= sample.obs_valid;
            sample_reg.image_index       <= sample.image_index;
            sample_reg.observed          <= sample.observed;
            sample_reg.predicted         <= sample.predicted;
            sample_reg.pixel_variability <= sample.pixel_variability;
        end
    end

    always_comb
    begin
        obs_q8  = {sample_reg.observed, 8'h00};
        res     = {obs_q8[23], obs_q8} - {sample_reg.predicted[23], sample_reg.predicted};
        lim     = gain_reg * sample_reg.pixel_variability;
        res_x   = {{8{res[24]}}, res};
        lim_x   = {lim[31], lim};
        thr_x   = {{9{thr_reg[23]}}, thr_reg};
        res2    = {res, 1'b0};
        thr2_x  = {{2{thr_reg[23]}}, thr_reg};
        thr_pos = !thr_reg[23] && (thr_reg != '0);
        thr_neg = thr_reg[23];
        alert   = (thr_pos && (res_x > thr_x) && (res_x > lim_x)) ||
                  (thr_neg && (res_x < thr_x) && (res_x < lim_x));
        calm    = (thr_pos && (res2 < thr2_x)) || (thr_neg && (res2 > thr2_x));
        if ({9'd0, sample_reg.image_index} > IdxLimit)
        begin
            cand_idx = IdxLimit[IDX_W-1:0];
        end
        else
        begin
            cand_idx = sample_reg.image_index;
        end
    end

    always_comb
    begin
        base       = sample_reg.first_of_pixel ? '0 : state_reg;
        state_next = base;
        if (sample_reg.obs_valid)
        begin
            if (!base.confirmed_flag)
            begin
                state_next.alert_run = alert ? sat_inc(base.alert_run) : '0;
                if (state_next.alert_run == 8'd1)
                begin
                    state_next.candidate = cand_idx;
                end
                if (state_next.alert_run == run_len_reg)
                begin
                    state_next.confirmed_flag = 1'b1;
                    state_next.confirm_count  = sat_inc(base.confirm_count);
                end
            end
            else
            begin
                state_next.calm_run = calm ? sat_inc(base.calm_run) : '0;
                if (state_next.calm_run == run_len_reg)
                begin
                    state_next.confirmed_flag = 1'b0;
                    state_next.revert_count   = sat_inc(base.revert_count);
                    state_next.alert_run      = '0;
                    state_next.calm_run       = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance && sample_reg.last_of_pixel)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && sample_reg.last_of_pixel)
        begin
            result_reg.detected        <= state_next.confirmed_flag;
            result_reg.candidate_index <= state_next.confirmed_flag ?
                                          state_next.candidate : '0;
            result_reg.confirm_events  <= state_next.confirm_count;
            result_reg.revert_events   <= state_next.revert_count;
        end
    end

    assign result.valid           = result_valid_reg;
    assign result.detected        = result_reg.detected;
    assign result.candidate_index = result_reg.candidate_index;
    assign result.confirm_events  = result_reg.confirm_events;
    assign result.revert_events   = result_reg.revert_events;

`include "residual_alert_confirm_revert_assert.svh"

    `RACR_ASSERT_SAME(a_detect_has_confirm, result.valid && result.detected, result.confirm_events != '0, "Detected result without any confirmation.")
    `RACR_ASSERT_SAME(a_no_detect_no_cand, result.valid && !result.detected, result.candidate_index == '0, "Candidate index set without detection.")
    `RACR_ASSERT_SAME(a_revert_le_confirm, 1'b1, state_reg.revert_count <= state_reg.confirm_count, "More reversions than confirmations.")
    `RACR_ASSERT_NEXT(a_last_gives_result, advance && sample_reg.last_of_pixel, result_valid_reg, "Last observation produced no result.")

endmodule
